/* hw/rtl/chip8_instruction_execute_top_macros.svh */
// Assertion macros shared by the execute unit.
`ifndef CHIP8_INSTRUCTION_EXECUTE_TOP_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_TOP_MACROS_SVH

// Same-cycle implication check.
`define C8X_ASSERT_IMPLY(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("c8x assertion failed");

// Next-cycle implication check.
`define C8X_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("c8x assertion failed");

`endif

/* hw/rtl/c8x_pkg.sv */
// Package: types, constants and helpers of the CHIP-8 execute unit.
`timescale 1ns / 1ps
package c8x_pkg;

    localparam int MEM_BYTES_DEF   = 4096;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int SCREEN_WIDTH    = 64;
    localparam int SCREEN_HEIGHT   = 32;
    localparam int FQ_DEPTH        = 2;
    localparam logic [11:0] PC_RESET = 12'd512;
    localparam logic [5:0]  KIND_LAST = 6'd36;

    typedef enum logic [5:0] {
        OP_CLS, OP_RET, OP_CALL, OP_JP, OP_SE_KK, OP_SNE_KK, OP_SE_XY, OP_LD_KK,
        OP_ADD_KK, OP_LD_XY, OP_OR, OP_AND, OP_XOR, OP_ADD_XY, OP_SUB, OP_SHR,
        OP_SUBN, OP_SHL, OP_SNE_XY, OP_LD_I, OP_JP_V0, OP_RND, OP_DRW, OP_SKP,
        OP_SKNP, OP_LD_DT_GET, OP_LD_KEY, OP_LD_DT_SET, OP_LD_ST, OP_ADD_I,
        OP_LD_F, OP_BCD, OP_STORE, OP_LOAD, OP_HOST_WR, OP_ROW_RD, OP_TICK, OP_NOP
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RDX, S_RDY, S_EXEC, S_BCD, S_STORE, S_LOAD_A, S_LOAD_D,
        S_DRAW_A, S_DRAW_D, S_ROW, S_DONE
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] operand;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic [7:0]  hdata;
    } item_t;

    typedef struct packed {
        logic [11:0] pc;
        logic [7:0]  flag;
        logic        waiting;
        logic        sound;
        logic [63:0] row;
    } res_t;

    function automatic op_t decode_kind(input logic [5:0] kind);
        op_t r;
        if (kind <= KIND_LAST)
            r = op_t'(kind);
        else
            r = OP_NOP;
        return r;
    endfunction

    // Lowest pressed key.
    function automatic logic [3:0] first_key(input logic [15:0] keys);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 15; i >= 0; i--)
            if (keys[i])
                r = 4'(i);
        return r;
    endfunction

    // Decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 units.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [13:0] h_prod;
        logic [1:0]  h;
        logic [7:0]  r;
        logic [15:0] t_prod;
        logic [3:0]  t;
        logic [7:0]  d;
        h_prod = 14'(v) * 14'd41;
        h      = h_prod[13:12];
        r      = v - (8'(h) * 8'd100);
        t_prod = 16'(r) * 16'd205;
        t      = t_prod[14:11];
        case (sel)
            2'd0:    d = 8'(h);
            2'd1:    d = 8'(t);
            default: d = r - (8'(t) * 8'd10);
        endcase
        return d;
    endfunction

endpackage

/* hw/rtl/c8x_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/c8x_front.sv */
// Front end: accepts requests, classifies the kind and queues them for execution.
`timescale 1ns / 1ps
module c8x_front
    import c8x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  kind,
    input  logic [11:0] operand,
    input  logic [15:0] keys_down,
    input  logic [7:0]  random_byte,
    input  logic [7:0]  host_data,
    output item_t       item,
    output logic        item_valid,
    input  logic        take
);
    localparam int PW = $clog2(FQ_DEPTH);

    item_t         fq_reg [FQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push, do_pop;

    assign full       = (count_reg == (PW+1)'(FQ_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = fq_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = take && item_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fq_reg[wr_ptr_reg].op      <= decode_kind(kind);
            fq_reg[wr_ptr_reg].operand <= operand;
            fq_reg[wr_ptr_reg].keys    <= keys_down;
            fq_reg[wr_ptr_reg].rnd     <= random_byte;
            fq_reg[wr_ptr_reg].hdata   <= host_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (PW+1)'(1);
            else if (!do_push && do_pop)
                count_reg <= count_reg - (PW+1)'(1);
        end
    end
endmodule

/* hw/rtl/c8x_back.sv */
// Back end: executes one queued request at a time against the machine state.
`timescale 1ns / 1ps
module c8x_back
    import c8x_pkg::*;
#(
    parameter int MEM_BYTES   = MEM_BYTES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  item_valid,
    output logic  take,
    output res_t  res,
    output logic  res_valid,
    input  logic  res_ready
);
    localparam int AW  = $clog2(MEM_BYTES);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int RW  = $clog2(SCREEN_HEIGHT);
    localparam int CW  = $clog2(SCREEN_WIDTH);

    state_t       state_reg, state_next;
    item_t        cmd_reg, cmd_next;
    logic [7:0]   v_reg [16];
    logic [7:0]   v_next [16];
    logic [7:0]   vx_reg, vx_next, vy_reg, vy_next;
    logic [15:0]  i_reg, i_next;
    logic [11:0]  pc_reg, pc_next;
    logic [7:0]   dt_reg, dt_next, st_reg, st_next;
    logic [SCW-1:0] sp_reg, sp_next, sp_m1;
    logic [11:0]  stack_reg [STACK_DEPTH];
    logic [11:0]  stack_next [STACK_DEPTH];
    logic [4:0]   cnt_reg, cnt_next;
    logic [RW-1:0] drow_reg, drow_next;
    logic [CW-1:0] dcol_reg, dcol_next;
    logic         wait_reg, wait_next;
    logic [63:0]  row_reg, row_next;
    logic         oor_reg, oor_next;
    logic [SCREEN_HEIGHT-1:0] dvalid_reg, dvalid_next;

    logic [3:0]   vsel, fx, fy, fn;
    logic [7:0]   v_rd, kk, mbyte, sum8;
    logic [11:0]  nnn, pc2, pc4;
    logic [16:0]  addr_full;
    logic         in_range;
    logic [5:0]   drow_sum;
    logic [RW-1:0] dr;
    logic [63:0]  bits, old_row;
    logic [8:0]   add9;
    logic [15:0]  i_add;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_q;
    logic          dsp_we;
    logic [RW-1:0] dsp_waddr, dsp_raddr;
    logic [63:0]   dsp_wdata, dsp_q;

    c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_q)
    );

    c8x_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_disp (
        .clk(clk), .we(dsp_we), .waddr(dsp_waddr), .wdata(dsp_wdata),
        .raddr(dsp_raddr), .rdata(dsp_q)
    );

    assign fx   = cmd_reg.operand[11:8];
    assign fy   = cmd_reg.operand[7:4];
    assign fn   = cmd_reg.operand[3:0];
    assign kk   = cmd_reg.operand[7:0];
    assign nnn  = cmd_reg.operand;
    assign pc2  = pc_reg + 12'd2;
    assign pc4  = pc_reg + 12'd4;
    assign v_rd = v_reg[vsel];
    assign sp_m1 = sp_reg - SCW'(1);
    assign addr_full = {1'b0, i_reg} + 17'(cnt_reg);
    assign in_range  = (addr_full < 17'(MEM_BYTES));
    assign drow_sum  = 6'(drow_reg) + 6'(cnt_reg[3:0]);
    assign dr        = drow_sum[RW-1:0];
    assign mbyte     = oor_reg ? 8'd0 : mem_q;
    assign bits      = {mbyte, 56'd0} >> dcol_reg;
    assign old_row   = dvalid_reg[dr] ? dsp_q : 64'd0;
    assign add9      = 9'(vx_reg) + 9'(vy_reg);
    assign sum8      = v_reg[0];
    assign i_add     = i_reg + 16'(vx_reg);

    assign res.pc      = pc_reg;
    assign res.flag    = v_reg[15];
    assign res.waiting = wait_reg;
    assign res.sound   = (st_reg != 8'd0);
    assign res.row     = row_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        v_next      = v_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        i_next      = i_reg;
        pc_next     = pc_reg;
        dt_next     = dt_reg;
        st_next     = st_reg;
        sp_next     = sp_reg;
        stack_next  = stack_reg;
        cnt_next    = cnt_reg;
        drow_next   = drow_reg;
        dcol_next   = dcol_reg;
        wait_next   = wait_reg;
        row_next    = row_reg;
        oor_next    = oor_reg;
        dvalid_next = dvalid_reg;
        take        = 1'b0;
        res_valid   = 1'b0;
        vsel        = fx;
        mem_we      = 1'b0;
        mem_waddr   = addr_full[AW-1:0];
        mem_wdata   = 8'd0;
        mem_raddr   = addr_full[AW-1:0];
        dsp_we      = 1'b0;
        dsp_waddr   = dr;
        dsp_wdata   = old_row ^ bits;
        dsp_raddr   = dr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    take       = 1'b1;
                    cmd_next   = item;
                    wait_next  = 1'b0;
                    row_next   = 64'd0;
                    state_next = S_RDX;
                end
            end
            S_RDX:
            begin
                vx_next    = v_rd;
                state_next = S_RDY;
            end
            S_RDY:
            begin
                vsel       = fy;
                vy_next    = v_rd;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                pc_next    = pc2;
                dsp_raddr  = cmd_reg.operand[RW-1:0];
                case (cmd_reg.op)
                    OP_CLS:    dvalid_next = '0;
                    OP_RET:
                    begin
                        if (sp_reg != '0)
                        begin
                            sp_next = sp_m1;
                            pc_next = stack_reg[sp_m1[SIW-1:0]];
                        end
                    end
                    OP_CALL:
                    begin
                        if (sp_reg < SCW'(STACK_DEPTH))
                        begin
                            stack_next[sp_reg[SIW-1:0]] = pc2;
                            sp_next = sp_reg + SCW'(1);
                            pc_next = nnn;
                        end
                    end
                    OP_JP:     pc_next = nnn;
                    OP_SE_KK:  pc_next = (vx_reg == kk) ? pc4 : pc2;
                    OP_SNE_KK: pc_next = (vx_reg != kk) ? pc4 : pc2;
                    OP_SE_XY:  pc_next = (vx_reg == vy_reg) ? pc4 : pc2;
                    OP_SNE_XY: pc_next = (vx_reg != vy_reg) ? pc4 : pc2;
                    OP_LD_KK:  v_next[fx] = kk;
                    OP_ADD_KK: v_next[fx] = vx_reg + kk;
                    OP_LD_XY:  v_next[fx] = vy_reg;
                    OP_OR:
                    begin
                        v_next[fx] = vx_reg | vy_reg;
                        v_next[15] = 8'd0;
                    end
                    OP_AND:
                    begin
                        v_next[fx] = vx_reg & vy_reg;
                        v_next[15] = 8'd0;
                    end
                    OP_XOR:
                    begin
                        v_next[fx] = vx_reg ^ vy_reg;
                        v_next[15] = 8'd0;
                    end
                    OP_ADD_XY:
                    begin
                        v_next[fx] = add9[7:0];
                        v_next[15] = 8'(add9[8]);
                    end
                    OP_SUB:
                    begin
                        v_next[fx] = vx_reg - vy_reg;
                        v_next[15] = 8'(vx_reg > vy_reg);
                    end
                    OP_SHR:
                    begin
                        v_next[fx] = vy_reg >> 1;
                        v_next[15] = 8'(vy_reg[0]);
                    end
                    OP_SUBN:
                    begin
                        v_next[fx] = vy_reg - vx_reg;
                        v_next[15] = 8'(vy_reg > vx_reg);
                    end
                    OP_SHL:
                    begin
                        v_next[fx] = vy_reg << 1;
                        v_next[15] = 8'(vy_reg[7]);
                    end
                    OP_LD_I:   i_next = 16'(nnn);
                    OP_JP_V0:  pc_next = 12'(sum8) + nnn;
                    OP_RND:    v_next[fx] = cmd_reg.rnd & kk;
                    OP_DRW:
                    begin
                        v_next[15] = 8'd0;
                        cnt_next   = 5'd0;
                        dcol_next  = vx_reg[CW-1:0];
                        drow_next  = vy_reg[RW-1:0];
                        pc_next    = pc_reg;
                        state_next = S_DRAW_A;
                    end
                    OP_SKP:
                        pc_next = (vx_reg[7:4] == 4'd0 && cmd_reg.keys[vx_reg[3:0]]) ? pc4 : pc2;
                    OP_SKNP:
                        pc_next = (vx_reg[7:4] == 4'd0 && !cmd_reg.keys[vx_reg[3:0]]) ? pc4 : pc2;
                    OP_LD_DT_GET: v_next[fx] = dt_reg;
                    OP_LD_KEY:
                    begin
                        if (cmd_reg.keys == 16'd0)
                        begin
                            wait_next = 1'b1;
                            pc_next   = pc_reg;
                        end
                        else
                            v_next[fx] = 8'(first_key(cmd_reg.keys));
                    end
                    OP_LD_DT_SET: dt_next = vx_reg;
                    OP_LD_ST:     st_next = vx_reg;
                    OP_ADD_I:
                    begin
                        i_next = i_add;
                        if (i_add[15:12] != 4'd0)
                            v_next[15] = 8'd1;
                    end
                    OP_LD_F:   i_next = 16'(vx_reg) * 16'd5;
                    OP_BCD:
                    begin
                        cnt_next   = 5'd0;
                        pc_next    = pc_reg;
                        state_next = S_BCD;
                    end
                    OP_STORE:
                    begin
                        cnt_next   = 5'd0;
                        pc_next    = pc_reg;
                        state_next = S_STORE;
                    end
                    OP_LOAD:
                    begin
                        cnt_next   = 5'd0;
                        pc_next    = pc_reg;
                        state_next = S_LOAD_A;
                    end
                    OP_HOST_WR:
                    begin
                        pc_next   = pc_reg;
                        mem_waddr = cmd_reg.operand[AW-1:0];
                        mem_wdata = cmd_reg.hdata;
                        mem_we    = (13'(cmd_reg.operand) < 13'(MEM_BYTES));
                    end
                    OP_ROW_RD:
                    begin
                        pc_next    = pc_reg;
                        state_next = S_ROW;
                    end
                    OP_TICK:
                    begin
                        pc_next = pc_reg;
                        if (dt_reg != 8'd0)
                            dt_next = dt_reg - 8'd1;
                        if (st_reg != 8'd0)
                            st_next = st_reg - 8'd1;
                    end
                    default:   pc_next = pc_reg;
                endcase
            end
            S_BCD:
            begin
                mem_wdata = bcd_digit(vx_reg, cnt_reg[1:0]);
                mem_we    = in_range;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2)
                begin
                    pc_next    = pc2;
                    state_next = S_DONE;
                end
            end
            S_STORE:
            begin
                vsel      = cnt_reg[3:0];
                mem_wdata = v_rd;
                mem_we    = in_range;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg[3:0] == fx)
                begin
                    i_next     = i_reg + 16'(fx) + 16'd1;
                    pc_next    = pc2;
                    state_next = S_DONE;
                end
            end
            S_LOAD_A:
            begin
                oor_next   = !in_range;
                state_next = S_LOAD_D;
            end
            S_LOAD_D:
            begin
                v_next[cnt_reg[3:0]] = mbyte;
                cnt_next   = cnt_reg + 5'd1;
                state_next = S_LOAD_A;
                if (cnt_reg[3:0] == fx)
                begin
                    i_next     = i_reg + 16'(fx) + 16'd1;
                    pc_next    = pc2;
                    state_next = S_DONE;
                end
            end
            S_DRAW_A:
            begin
                // stop after n rows or at the bottom edge
                if (cnt_reg[3:0] != fn && cnt_reg[4] == 1'b0 && !drow_sum[RW])
                begin
                    oor_next   = !in_range;
                    state_next = S_DRAW_D;
                end
                else
                begin
                    pc_next    = pc2;
                    state_next = S_DONE;
                end
            end
            S_DRAW_D:
            begin
                dsp_we          = 1'b1;
                dvalid_next[dr] = 1'b1;
                if ((old_row & bits) != 64'd0)
                    v_next[15] = 8'd1;
                cnt_next   = cnt_reg + 5'd1;
                state_next = S_DRAW_A;
            end
            S_ROW:
            begin
                if (cmd_reg.operand[11:RW] == '0 && dvalid_reg[cmd_reg.operand[RW-1:0]])
                    row_next = dsp_q;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        stack_reg <= stack_next;
        cnt_reg   <= cnt_next;
        drow_reg  <= drow_next;
        dcol_reg  <= dcol_next;
        row_reg   <= row_next;
        oor_reg   <= oor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            v_reg      <= '{default: 8'd0};
            i_reg      <= 16'd0;
            pc_reg     <= PC_RESET;
            dt_reg     <= 8'd0;
            st_reg     <= 8'd0;
            sp_reg     <= '0;
            wait_reg   <= 1'b0;
            dvalid_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            v_reg      <= v_next;
            i_reg      <= i_next;
            pc_reg     <= pc_next;
            dt_reg     <= dt_next;
            st_reg     <= st_next;
            sp_reg     <= sp_next;
            wait_reg   <= wait_next;
            dvalid_reg <= dvalid_next;
        end
    end
endmodule

/* hw/rtl/chip8_instruction_execute_top.sv */
// Top level of the CHIP-8 execute unit: front queue, executor and result register.
// Each request passes the executor states IDLE (accept), RDX and RDY (register reads), EXEC
// and DONE, with extra states for row read, BCD, register store/load and per-row draw.
// One request executes at a time; the next is taken from the queue only once the result
// is handed to the result register, while the front queue buffers up to two more requests.
// Reset (async, active low) sets pc to 512, clears V0-VF, I, timers, stack count and the
// per-row display valid bits; memory and the return stack are not cleared.
`timescale 1ns / 1ps
`include "chip8_instruction_execute_top_macros.svh"
module chip8_instruction_execute_top
    import c8x_pkg::*;
#(
    parameter int MEM_BYTES   = MEM_BYTES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  kind,
    input  logic [11:0] operand,
    input  logic [15:0] keys_down,
    input  logic [7:0]  random_byte,
    input  logic [7:0]  host_data,
    output logic        empty,
    input  logic        pop,
    output logic [11:0] pc_out,
    output logic [7:0]  flag_out,
    output logic        waiting_key,
    output logic        sound_on,
    output logic [63:0] row_bits
);
    item_t fe_item;
    logic  fe_valid, take;
    res_t  res, out_reg;
    logic  res_valid, res_ready, out_valid_reg;

    c8x_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .operand(operand), .keys_down(keys_down), .random_byte(random_byte),
        .host_data(host_data), .item(fe_item), .item_valid(fe_valid), .take(take)
    );

    c8x_back #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .item(fe_item), .item_valid(fe_valid), .take(take),
        .res(res), .res_valid(res_valid), .res_ready(res_ready)
    );

    assign res_ready = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    assign pc_out      = out_reg.pc;
    assign flag_out    = out_reg.flag;
    assign waiting_key = out_reg.waiting;
    assign sound_on    = out_reg.sound;
    assign row_bits    = out_reg.row;

    `C8X_ASSERT_IMPLY(a_take_needs_item, clk, rst_n, take, fe_valid)
    `C8X_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !empty && !res_valid, empty)
    `C8X_ASSERT_NEXT(a_result_lands, clk, rst_n, res_valid && res_ready, !empty)
endmodule

/* test/chip8_instruction_execute_top_tb.sv */
// Self-checking testbench for the CHIP-8 execute unit: directed table, then random requests.
`timescale 1ns / 1ps
module chip8_instruction_execute_top_tb;
    import c8x_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [5:0]  kind;
        logic [11:0] operand;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic [7:0]  hdata;
        bit          typed;
        logic [11:0] pc;
        logic [7:0]  flag;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [5:0]  kind;
    logic [11:0] operand;
    logic [15:0] keys_down;
    logic [7:0]  random_byte;
    logic [7:0]  host_data;
    logic        empty;
    logic        pop;
    logic [11:0] pc_out;
    logic [7:0]  flag_out;
    logic        waiting_key;
    logic        sound_on;
    logic [63:0] row_bits;

    // Shadow machine state
    logic [7:0]  sh_mem [MEM_BYTES_DEF];
    logic [63:0] sh_disp [SCREEN_HEIGHT];
    logic [7:0]  sh_v [16];
    logic [15:0] sh_i;
    logic [11:0] sh_stack [STACK_DEPTH_DEF];
    int          sh_sp;
    logic [11:0] sh_pc;
    logic [7:0]  sh_dt;
    logic [7:0]  sh_st;

    res_t        expected_q [$];
    int          errors;
    int          stall_cnt;
    bit          calm;
    dir_row_t    dir_tab [24];

    chip8_instruction_execute_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .operand     (operand),
        .keys_down   (keys_down),
        .random_byte (random_byte),
        .host_data   (host_data),
        .empty       (empty),
        .pop         (pop),
        .pc_out      (pc_out),
        .flag_out    (flag_out),
        .waiting_key (waiting_key),
        .sound_on    (sound_on),
        .row_bits    (row_bits)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] mem_byte(input logic [16:0] a);
        return (a < MEM_BYTES_DEF) ? sh_mem[a] : 8'd0;
    endfunction

    // True when the 16 bytes from I on were all written or lie beyond memory.
    function automatic bit span_written();
        logic [16:0] a;
        bit          ok;
        ok = 1'b1;
        for (int j = 0; j < 16; j++)
        begin
            a = {1'b0, sh_i} + 17'(j);
            if (a < MEM_BYTES_DEF && $isunknown(sh_mem[a]))
                ok = 1'b0;
        end
        return ok;
    endfunction

    // Execute one request on the shadow state and return the outcome.
    function automatic res_t execute(input logic [5:0] k, input logic [11:0] op,
                                     input logic [15:0] keys, input logic [7:0] rnd,
                                     input logic [7:0] hd);
        res_t        r;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, vx, vy, b;
        logic [11:0] nxt, skp, pc;
        logic [8:0]  sum;
        logic [63:0] bits;
        int          col, row0, i;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        kk = op[7:0];
        vx = sh_v[x];
        vy = sh_v[y];
        pc = sh_pc;
        nxt = sh_pc + 12'd2;
        skp = sh_pc + 12'd4;
        r = '0;
        case (decode_kind(k))
            OP_CLS:
            begin
                for (i = 0; i < SCREEN_HEIGHT; i++)
                    sh_disp[i] = '0;
                pc = nxt;
            end
            OP_RET:
            begin
                if (sh_sp > 0)
                begin
                    sh_sp--;
                    pc = sh_stack[sh_sp];
                end
                else
                    pc = nxt;
            end
            OP_CALL:
            begin
                if (sh_sp < STACK_DEPTH_DEF)
                begin
                    sh_stack[sh_sp] = nxt;
                    sh_sp++;
                    pc = op;
                end
                else
                    pc = nxt;
            end
            OP_JP:     pc = op;
            OP_SE_KK:  pc = (vx == kk) ? skp : nxt;
            OP_SNE_KK: pc = (vx != kk) ? skp : nxt;
            OP_SE_XY:  pc = (vx == vy) ? skp : nxt;
            OP_LD_KK:  begin sh_v[x] = kk; pc = nxt; end
            OP_ADD_KK: begin sh_v[x] = vx + kk; pc = nxt; end
            OP_LD_XY:  begin sh_v[x] = vy; pc = nxt; end
            OP_OR:     begin sh_v[x] = vx | vy; sh_v[15] = 0; pc = nxt; end
            OP_AND:    begin sh_v[x] = vx & vy; sh_v[15] = 0; pc = nxt; end
            OP_XOR:    begin sh_v[x] = vx ^ vy; sh_v[15] = 0; pc = nxt; end
            OP_ADD_XY:
            begin
                sum = {1'b0, vx} + {1'b0, vy};
                sh_v[x] = sum[7:0];
                sh_v[15] = {7'd0, sum[8]};
                pc = nxt;
            end
            OP_SUB:    begin sh_v[x] = vx - vy; sh_v[15] = {7'd0, vx > vy}; pc = nxt; end
            OP_SHR:    begin sh_v[x] = vy >> 1; sh_v[15] = {7'd0, vy[0]}; pc = nxt; end
            OP_SUBN:   begin sh_v[x] = vy - vx; sh_v[15] = {7'd0, vy > vx}; pc = nxt; end
            OP_SHL:    begin sh_v[x] = vy << 1; sh_v[15] = {7'd0, vy[7]}; pc = nxt; end
            OP_SNE_XY: pc = (vx != vy) ? skp : nxt;
            OP_LD_I:   begin sh_i = {4'd0, op}; pc = nxt; end
            OP_JP_V0:  pc = {4'd0, sh_v[0]} + op;
            OP_RND:    begin sh_v[x] = rnd & kk; pc = nxt; end
            OP_DRW:
            begin
                col = vx % 64;
                row0 = vy % 32;
                sh_v[15] = 0;
                for (i = 0; i < n && row0 + i < SCREEN_HEIGHT; i++)
                begin
                    b = mem_byte({1'b0, sh_i} + 17'(i));
                    bits = {b, 56'd0} >> col;
                    if ((sh_disp[row0 + i] & bits) != 0)
                        sh_v[15] = 1;
                    sh_disp[row0 + i] ^= bits;
                end
                pc = nxt;
            end
            OP_SKP:    pc = (vx < 16 && keys[vx[3:0]]) ? skp : nxt;
            OP_SKNP:   pc = (vx < 16 && !keys[vx[3:0]]) ? skp : nxt;
            OP_LD_DT_GET: begin sh_v[x] = sh_dt; pc = nxt; end
            OP_LD_KEY:
            begin
                if (keys == 0)
                    r.waiting = 1'b1;
                else
                begin
                    for (i = 15; i >= 0; i--)
                        if (keys[i])
                            sh_v[x] = 8'(i);
                    pc = nxt;
                end
            end
            OP_LD_DT_SET: begin sh_dt = vx; pc = nxt; end
            OP_LD_ST:  begin sh_st = vx; pc = nxt; end
            OP_ADD_I:
            begin
                sh_i = sh_i + {8'd0, vx};
                if (sh_i[15:12] != 0)
                    sh_v[15] = 1;
                pc = nxt;
            end
            OP_LD_F:   begin sh_i = 16'(vx) * 16'd5; pc = nxt; end
            OP_BCD:
            begin
                for (i = 0; i < 3; i++)
                    if (32'(sh_i) + i < MEM_BYTES_DEF)
                        sh_mem[32'(sh_i) + i] = (i == 0) ? vx / 100 :
                                                (i == 1) ? (vx / 10) % 10 : vx % 10;
                pc = nxt;
            end
            OP_STORE:
            begin
                for (i = 0; i <= x; i++)
                    if (32'(sh_i) + i < MEM_BYTES_DEF)
                        sh_mem[32'(sh_i) + i] = sh_v[i];
                sh_i = sh_i + 16'(x) + 16'd1;
                pc = nxt;
            end
            OP_LOAD:
            begin
                for (i = 0; i <= x; i++)
                    sh_v[i] = mem_byte({1'b0, sh_i} + 17'(i));
                sh_i = sh_i + 16'(x) + 16'd1;
                pc = nxt;
            end
            OP_HOST_WR: sh_mem[op] = hd;
            OP_ROW_RD:
            begin
                if (op < SCREEN_HEIGHT)
                    r.row = sh_disp[op];
            end
            OP_TICK:
            begin
                if (sh_dt != 0)
                    sh_dt--;
                if (sh_st != 0)
                    sh_st--;
            end
            default: ;
        endcase
        sh_pc = pc;
        r.pc = pc;
        r.flag = sh_v[15];
        r.sound = (sh_st != 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    // Hold push high across back-to-back requests; idle only when a gap is drawn.
    task automatic send_request(input logic [5:0] k, input logic [11:0] op,
                                input logic [15:0] keys, input logic [7:0] rnd,
                                input logic [7:0] hd, input bit typed,
                                input logic [11:0] t_pc, input logic [7:0] t_flag);
        res_t r;
        if (!calm && $urandom_range(99) < 36)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        operand <= op;
        keys_down <= keys;
        random_byte <= rnd;
        host_data <= hd;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        r = execute(k, op, keys, rnd, hd);
        if (typed)
        begin
            r.pc = t_pc;
            r.flag = t_flag;
        end
        expected_q.push_back(r);
    endtask

    // Result side: check on accept, then draw the next pop.
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (pc_out !== e.pc) report_mismatch("pc_out", 64'(pc_out), 64'(e.pc));
                if (flag_out !== e.flag) report_mismatch("flag_out", 64'(flag_out), 64'(e.flag));
                if (waiting_key !== e.waiting)
                    report_mismatch("waiting_key", 64'(waiting_key), 64'(e.waiting));
                if (sound_on !== e.sound)
                    report_mismatch("sound_on", 64'(sound_on), 64'(e.sound));
                if (row_bits !== e.row) report_mismatch("row_bits", row_bits, e.row);
            end
        end
        pop <= calm || ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("chip8_instruction_execute_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int          i, pick, n;
        logic [5:0]  k;
        logic [11:0] op;
        logic [15:0] keys;
        clk = 0;
        rst_n = 0;
        push = 0;
        pop = 0;
        kind = '0;
        operand = '0;
        keys_down = '0;
        random_byte = '0;
        host_data = '0;
        errors = 0;
        stall_cnt = 0;
        calm = 0;
        for (i = 0; i < SCREEN_HEIGHT; i++)
            sh_disp[i] = '0;
        for (i = 0; i < 16; i++)
            sh_v[i] = '0;
        sh_i = '0;
        sh_sp = 0;
        sh_pc = PC_RESET;
        sh_dt = '0;
        sh_st = '0;

        dir_tab = '{
            '{OP_ROW_RD,    12'h000, 16'h0000, 8'h00, 8'h00, 1, 12'd512, 8'd0},
            '{OP_LD_KK,     12'h0FF, 16'h0000, 8'h00, 8'h00, 1, 12'd514, 8'd0},
            '{OP_LD_KK,     12'h101, 16'h0000, 8'h00, 8'h00, 1, 12'd516, 8'd0},
            '{OP_ADD_XY,    12'h010, 16'h0000, 8'h00, 8'h00, 1, 12'd518, 8'd1},
            '{OP_SUB,       12'h010, 16'h0000, 8'h00, 8'h00, 1, 12'd520, 8'd0},
            '{OP_RET,       12'h000, 16'h0000, 8'h00, 8'h00, 1, 12'd522, 8'd0},
            '{OP_JP,        12'hFFE, 16'h0000, 8'h00, 8'h00, 1, 12'hFFE, 8'd0},
            '{OP_SE_KK,     12'h0FF, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_CALL,      12'hABC, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_RET,       12'h000, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_LD_KK,     12'hFFF, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_SHL,       12'hF0F, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_JP_V0,     12'hFFF, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_LD_I,      12'hFF0, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_LD_KK,     12'h23C, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_DRW,       12'h22F, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_DRW,       12'h22F, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_LD_KEY,    12'h300, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_LD_KEY,    12'h300, 16'h8000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_LD_ST,     12'h300, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_STORE,     12'hF00, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_ROW_RD,    12'h01F, 16'h0000, 8'h00, 8'h00, 0, 12'd0, 8'd0},
            '{OP_RND,       12'h5A5, 16'hFFFF, 8'hFF, 8'h00, 0, 12'd0, 8'd0},
            '{6'd63,        12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 0, 12'd0, 8'd0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the low sprite area and the top 16 bytes of memory.
        calm = 1;
        for (i = 0; i < 80; i++)
            send_request(OP_HOST_WR, (i < 64) ? 12'(i) : 12'(4016 + i), 16'(i), 8'(i),
                         8'($urandom_range(255)), 0, 0, 0);
        calm = 0;

        foreach (dir_tab[j])
            send_request(dir_tab[j].kind, dir_tab[j].operand, dir_tab[j].keys,
                         dir_tab[j].rnd, dir_tab[j].hdata, dir_tab[j].typed,
                         dir_tab[j].pc, dir_tab[j].flag);

        for (n = 0; n < 500; n++)
        begin
            calm = (n >= 200 && n < 290);
            pick = $urandom_range(99);
            if (pick < 4)
                k = 6'($urandom_range(37, 63));
            else if (pick < 12)
                k = (pick < 8) ? 6'(OP_CALL) : 6'(OP_RET);
            else if (pick < 16)
                k = 6'(OP_TICK);
            else
                k = 6'($urandom_range(0, 36));
            op = 12'($urandom_range(4095));
            if (k == OP_ROW_RD && $urandom_range(3) != 0)
                op = 12'($urandom_range(31));
            keys = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom_range(65535));
            // Point I at written bytes before a draw or load would read unwritten ones.
            if ((k == OP_DRW || k == OP_LOAD) && !span_written())
                send_request(OP_LD_I, 12'($urandom_range(48)), 16'h0, 8'h0, 8'h0, 0, 0, 0);
            send_request(k, op, keys, 8'($urandom_range(255)), 8'($urandom_range(255)), 0, 0, 0);
        end
        push <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("chip8_instruction_execute_top_tb: PASS");
        else
            $display("chip8_instruction_execute_top_tb: FAIL");
        $finish;
    end

endmodule

/* chip8_instruction_execute_top.f */
+incdir+hw/rtl
hw/rtl/c8x_pkg.sv
hw/rtl/c8x_ram.sv
hw/rtl/c8x_front.sv
hw/rtl/c8x_back.sv
hw/rtl/chip8_instruction_execute_top.sv
test/chip8_instruction_execute_top_tb.sv
